// ----- hw/rtl/thlc_pkg.sv -----
// Shared types, weight-class table and divider constants for the
// tap/hold classifier. No dependencies.
package thlc_pkg;

  typedef logic [7:0]  code_t;
  typedef logic [15:0] ms_t;
  typedef logic [7:0]  wait_t;
  typedef logic [1:0]  div_t;

  localparam wait_t MIN_WAIT_RESET = 8'd50;

  // Divisor codes for the boundary timeout.
  localparam div_t DIV_ZERO = 2'd0;
  localparam div_t DIV_290  = 2'd1;
  localparam div_t DIV_175  = 2'd2;
  localparam div_t DIV_1000 = 2'd3;

  // Quotients are formed as (n * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT, which is
  // exact for every numerator below 256 * d.
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 21;
  localparam int NUM_W       = 27;
  localparam int LIM_W       = 18;
  localparam int PROD_W      = LIM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_290  = RECIP_W'(((2**RECIP_SHIFT) + 289) / 290);
  localparam logic [RECIP_W-1:0] RECIP_175  = RECIP_W'(((2**RECIP_SHIFT) + 174) / 175);
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(((2**RECIP_SHIFT) + 999) / 1000);

  localparam logic [LIM_W-1:0] LIMIT_290  = LIM_W'(256 * 290);
  localparam logic [LIM_W-1:0] LIMIT_175  = LIM_W'(256 * 175);
  localparam logic [LIM_W-1:0] LIMIT_1000 = LIM_W'(256 * 1000);

  typedef struct packed {
    logic [8:0]  wy_mag;
    logic [17:0] b_mag;
    wait_t       guard;
    div_t        rel_div;
  } weights_t;

  function automatic weights_t class_of(input code_t code);
    weights_t w;
    unique case (code) inside
      8'h2B, 8'h2A, 8'h2C, 8'h28: begin
        w = '{wy_mag: 9'd290, b_mag: 18'd108677, guard: 8'd250, rel_div: DIV_290};
      end
      8'h33, 8'h1D: begin
        w = '{wy_mag: 9'd175, b_mag: 18'd127712, guard: 8'd250, rel_div: DIV_175};
      end
      8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h1A, 8'h12: begin
        w = '{wy_mag: 9'd0, b_mag: 18'd250000, guard: 8'd250, rel_div: DIV_ZERO};
      end
      default: begin
        w = '{wy_mag: 9'd0, b_mag: 18'd200000, guard: 8'd200, rel_div: DIV_ZERO};
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/thlc_in_if.sv -----
// Input channel of the tap/hold classifier: one pending key per item.
// Depends on thlc_pkg.
interface thlc_in_if import thlc_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t tap_code;
  logic  release_known;
  ms_t   release_ms;
  logic  other_known;
  ms_t   other_press_ms;
  ms_t   elapsed_ms;
  logic  forced_tap;

  modport source (
    output valid, tap_code, release_known, release_ms, other_known, other_press_ms,
           elapsed_ms, forced_tap,
    input  ready
  );
  modport sink (
    input  valid, tap_code, release_known, release_ms, other_known, other_press_ms,
           elapsed_ms, forced_tap,
    output ready
  );
endinterface

// ----- hw/rtl/thlc_out_if.sv -----
// Output channel of the tap/hold classifier: one decision per item.
// Depends on thlc_pkg.
interface thlc_out_if import thlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               settle;
  logic               hold;
  wait_t              timeout_ms;
  logic signed [31:0] score;

  modport source (output valid, settle, hold, timeout_ms, score, input ready);
  modport sink (input valid, settle, hold, timeout_ms, score, output ready);
endinterface

// ----- hw/rtl/tap_hold_linear_classifier.sv -----
// Tap/hold classifier: four-stage pipeline; an accepted item passes through stages 1 to 4 and
// its result waits in the stage 4 output register until taken; one item is accepted per cycle
// while the output drains.
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances, so a bubble is filled even while a result waits at the output.
// Reset clears all valid bits and sets min_wait to 50 ms.
// Depends on thlc_pkg, thlc_in_if and thlc_out_if.
module tap_hold_linear_classifier import thlc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  wait_t         cfg_wr_data,
  thlc_in_if.sink       key,
  thlc_out_if.source    decision
);

  wait_t min_wait;

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // Stage 1: class lookup, score and boundary numerator.
  logic               s1_bnd, s1_imm, s1_both, s1_hold;
  logic signed [31:0] s1_score;
  logic [NUM_W-1:0]   s1_num;
  div_t               s1_div;
  wait_t              s1_guard;
  ms_t                s1_elapsed;

  // Stage 2: range checks and reciprocal product.
  logic               s2_bnd, s2_imm, s2_hold, s2_neg, s2_big, s2_zero;
  logic signed [31:0] s2_score;
  logic [PROD_W-1:0]  s2_prod;
  wait_t              s2_guard;
  ms_t                s2_elapsed;

  // Stage 3: clamped timeout.
  logic               s3_imm, s3_hold;
  logic signed [31:0] s3_score;
  wait_t              s3_timeout;
  ms_t                s3_elapsed;

  // Stage 4: output register.
  logic               s4_settle, s4_hold;
  wait_t              s4_timeout;
  logic signed [31:0] s4_score;

  weights_t           w;
  logic [31:0]        score_c;
  logic [NUM_W-1:0]   num_rel, num_oth;
  logic               rel_only, oth_only, both;
  logic [RECIP_W-1:0] recip;
  logic [LIM_W-1:0]   limit;
  wait_t              quot, t_clamp;

  assign rdy4 = !s4_valid || decision.ready;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign key.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_wait <= MIN_WAIT_RESET;
    end else if (cfg_wr_en) begin
      min_wait <= cfg_wr_data;
    end
  end

  always_comb begin
    w        = class_of(key.tap_code);
    both     = key.release_known && key.other_known;
    rel_only = key.release_known && !key.other_known;
    oth_only = key.other_known && !key.release_known;
    score_c  = 32'(key.release_ms) * 32'd1000 - 32'(key.other_press_ms) * 32'(w.wy_mag)
               - 32'(w.b_mag);
    num_rel  = NUM_W'(key.release_ms) * NUM_W'(1000) - NUM_W'(w.b_mag);
    num_oth  = NUM_W'(key.other_press_ms) * NUM_W'(w.wy_mag) + NUM_W'(w.b_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_imm     <= key.forced_tap || both;
      s1_both    <= !key.forced_tap && both;
      s1_bnd     <= !key.forced_tap && (rel_only || oth_only);
      s1_hold    <= !key.forced_tap && !rel_only;
      s1_score   <= (!key.forced_tap && both) ? signed'(score_c) : 32'sd0;
      s1_num     <= rel_only ? num_rel : num_oth;
      s1_div     <= rel_only ? w.rel_div : DIV_1000;
      s1_guard   <= w.guard;
      s1_elapsed <= key.elapsed_ms;
    end
  end

  always_comb begin
    unique case (s1_div)
      DIV_290: begin
        recip = RECIP_290;
        limit = LIMIT_290;
      end
      DIV_175: begin
        recip = RECIP_175;
        limit = LIMIT_175;
      end
      DIV_1000: begin
        recip = RECIP_1000;
        limit = LIMIT_1000;
      end
      default: begin
        recip = '0;
        limit = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_bnd     <= s1_bnd;
      s2_imm     <= s1_imm;
      s2_hold    <= s1_both ? (!s1_score[31] && (s1_score != 32'sd0)) : s1_hold;
      s2_neg     <= s1_num[NUM_W-1];
      s2_big     <= !s1_num[NUM_W-1] && (s1_num[NUM_W-2:0] >= (NUM_W-1)'(limit));
      s2_zero    <= s1_div == DIV_ZERO;
      s2_prod    <= PROD_W'(s1_num[LIM_W-1:0]) * PROD_W'(recip);
      s2_score   <= s1_score;
      s2_guard   <= s1_guard;
      s2_elapsed <= s1_elapsed;
    end
  end

  always_comb begin
    quot = s2_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    if (s2_zero || s2_neg) begin
      t_clamp = min_wait;
    end else if (s2_big) begin
      t_clamp = s2_guard;
    end else if (quot < min_wait) begin
      t_clamp = min_wait;
    end else if (quot > s2_guard) begin
      t_clamp = s2_guard;
    end else begin
      t_clamp = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_imm     <= s2_imm;
      s3_hold    <= s2_hold;
      s3_score   <= s2_score;
      s3_timeout <= s2_bnd ? t_clamp : s2_guard;
      s3_elapsed <= s2_elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (rdy4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_settle  <= s3_imm || (s3_elapsed >= {8'h00, s3_timeout});
      s4_hold    <= s3_hold;
      s4_timeout <= s3_timeout;
      s4_score   <= s3_score;
    end
  end

  assign decision.valid      = s4_valid;
  assign decision.settle     = s4_settle;
  assign decision.hold       = s4_hold;
  assign decision.timeout_ms = s4_timeout;
  assign decision.score      = s4_score;

endmodule

// ----- bench/tap_hold_linear_classifier_tb.sv -----
// Self-checking bench for tap_hold_linear_classifier: directed key cases, then random
// items under varied flow control; decisions checked against listed values or a model.
// Depends on thlc_pkg, thlc_in_if, thlc_out_if and the classifier RTL.
module tap_hold_linear_classifier_tb import thlc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 4000;
  localparam int ITEMS_PER_SETTING = 225;

  typedef struct packed {
    code_t tap_code;
    logic  release_known;
    ms_t   release_ms;
    logic  other_known;
    ms_t   other_press_ms;
    ms_t   elapsed_ms;
    logic  forced_tap;
  } key_item_t;

  typedef struct packed {
    logic               settle;
    logic               hold;
    wait_t              timeout_ms;
    logic signed [31:0] score;
  } decision_t;

  typedef struct {
    key_item_t k;
    bit        typed;
    decision_t want;
  } directed_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_wr_en;
  wait_t cfg_wr_data;

  thlc_in_if  keys ();
  thlc_out_if decisions ();

  tap_hold_linear_classifier DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .key        (keys),
    .decision   (decisions)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  decision_t pending_decisions[$];
  wait_t     min_wait_copy;
  int        mismatches = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        stuck_cycles = 0;
  bit        next_is_typed = 1'b0;
  decision_t typed_decision = '0;

  code_t class_codes[17] = '{8'h2B, 8'h2A, 8'h2C, 8'h28, 8'h33, 8'h1D, 8'h04, 8'h16,
                             8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h1A, 8'h12};
  int    gap_plan[4] = '{0, 46, 0, 29};
  int    stall_plan[4] = '{0, 0, 46, 29};
  wait_t wait_settings[8] = '{8'd0, 8'd255, 8'd120, 8'd250, 8'd200, 8'd1, 8'd60, 8'd50};

  function automatic longint clamp_wait(longint t, longint floor_ms, longint guard);
    if (t < floor_ms) return floor_ms;
    if (t > guard) return guard;
    return t;
  endfunction

  function automatic decision_t predict_decision(key_item_t k, wait_t min_wait);
    longint wy, bias, guard, x, y, el, t, s, mw;
    decision_t d;
    x = k.release_ms;
    y = k.other_press_ms;
    el = k.elapsed_ms;
    mw = min_wait;
    case (k.tap_code)
      8'h2B, 8'h2A, 8'h2C, 8'h28: begin
        wy = -290; bias = -108677; guard = 250;
      end
      8'h33, 8'h1D: begin
        wy = -175; bias = -127712; guard = 250;
      end
      8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h1A, 8'h12: begin
        wy = 0; bias = -250000; guard = 250;
      end
      default: begin
        wy = 0; bias = -200000; guard = 200;
      end
    endcase
    d = '0;
    d.hold = 1'b1;
    t = guard;
    if (k.forced_tap) begin
      d.settle = 1'b1;
      d.hold = 1'b0;
    end else if (k.release_known && k.other_known) begin
      s = 1000 * x + wy * y + bias;
      d.score = 32'(s);
      d.hold = (s > 0);
      d.settle = 1'b1;
    end else begin
      if (k.release_known) begin
        d.hold = 1'b0;
        t = (wy == 0) ? mw : clamp_wait(-(1000 * x + bias) / wy, mw, guard);
      end else if (k.other_known) begin
        t = clamp_wait(-(wy * y + bias) / 1000, mw, guard);
      end
      d.settle = (el >= t);
    end
    d.timeout_ms = 8'(t);
    return d;
  endfunction

  function automatic key_item_t make_key(code_t code, logic rk, ms_t x, logic ok, ms_t y,
                                         ms_t el, logic ft);
    return '{code, rk, x, ok, y, el, ft};
  endfunction

  function automatic decision_t make_decision(logic settle, logic hold, wait_t to, int score);
    return '{settle, hold, to, score};
  endfunction

  function automatic ms_t pick_ms(int near_limit);
    return ($urandom_range(3) == 0) ? ms_t'($urandom) : ms_t'($urandom_range(near_limit));
  endfunction

  function automatic key_item_t random_key();
    key_item_t k;
    k.tap_code = $urandom_range(1) ? class_codes[$urandom_range(16)] : code_t'($urandom);
    k.release_known = 1'($urandom_range(1));
    k.release_ms = pick_ms(400);
    k.other_known = 1'($urandom_range(1));
    k.other_press_ms = pick_ms(400);
    k.elapsed_ms = pick_ms(300);
    k.forced_tap = ($urandom_range(9) == 0);
    return k;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic offer_key(key_item_t k, bit typed, decision_t want);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      keys.valid <= 1'b0;
      @(negedge clk);
    end
    next_is_typed = typed;
    typed_decision = want;
    keys.valid <= 1'b1;
    keys.tap_code <= k.tap_code;
    keys.release_known <= k.release_known;
    keys.release_ms <= k.release_ms;
    keys.other_known <= k.other_known;
    keys.other_press_ms <= k.other_press_ms;
    keys.elapsed_ms <= k.elapsed_ms;
    keys.forced_tap <= k.forced_tap;
    do @(posedge clk); while (!keys.ready);
  endtask

  task automatic drain_decisions();
    @(negedge clk);
    keys.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(negedge clk);
  endtask

  task automatic set_min_wait(wait_t value);
    drain_decisions();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    decisions.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    key_item_t seen;
    decision_t got;
    decision_t want;
    if (rst) begin
      min_wait_copy = MIN_WAIT_RESET;
    end else begin
      if (cfg_wr_en) min_wait_copy = cfg_wr_data;
      if (keys.valid && keys.ready) begin
        seen = '{keys.tap_code, keys.release_known, keys.release_ms, keys.other_known,
                 keys.other_press_ms, keys.elapsed_ms, keys.forced_tap};
        pending_decisions.push_back(next_is_typed ? typed_decision
                                                  : predict_decision(seen, min_wait_copy));
      end
      if (decisions.valid && decisions.ready) begin
        got = '{decisions.settle, decisions.hold, decisions.timeout_ms, decisions.score};
        if (pending_decisions.size() == 0) begin
          report_mismatch("decision with no item outstanding");
        end else begin
          want = pending_decisions.pop_front();
          if (got.settle !== want.settle)
            report_mismatch($sformatf("settle %0b, expected %0b", got.settle, want.settle));
          if (got.hold !== want.hold)
            report_mismatch($sformatf("hold %0b, expected %0b", got.hold, want.hold));
          if (got.timeout_ms !== want.timeout_ms)
            report_mismatch($sformatf("timeout_ms %0d, expected %0d",
                                      got.timeout_ms, want.timeout_ms));
          if (got.score !== want.score)
            report_mismatch($sformatf("score %0d, expected %0d", got.score, want.score));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (keys.valid && keys.ready) || (decisions.valid && decisions.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t rows[$];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    keys.valid = 1'b0;
    keys.tap_code = '0;
    keys.release_known = 1'b0;
    keys.release_ms = '0;
    keys.other_known = 1'b0;
    keys.other_press_ms = '0;
    keys.elapsed_ms = '0;
    keys.forced_tap = 1'b0;
    decisions.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.push_back('{make_key(8'h2C, 0, 0, 0, 0, 0, 1), 1, make_decision(1, 0, 250, 0)});
    rows.push_back('{make_key(8'h00, 1, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1), 1,
                     make_decision(1, 0, 200, 0)});
    rows.push_back('{make_key(8'hFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0), 1,
                     make_decision(0, 1, 200, 0)});
    rows.push_back('{make_key(8'hFF, 0, 0, 0, 0, 16'hFFFF, 0), 1, make_decision(1, 1, 200, 0)});
    rows.push_back('{make_key(8'h04, 0, 0, 0, 0, 250, 0), 1, make_decision(1, 1, 250, 0)});
    rows.push_back('{make_key(8'h04, 0, 0, 0, 0, 249, 0), 1, make_decision(0, 1, 250, 0)});
    rows.push_back('{make_key(8'h2A, 1, 0, 1, 0, 0, 0), 1, make_decision(1, 0, 250, -108677)});
    rows.push_back('{make_key(8'h04, 1, 300, 0, 0, 50, 0), 1, make_decision(1, 0, 50, 0)});
    rows.push_back('{make_key(8'h00, 1, 300, 0, 0, 49, 0), 1, make_decision(0, 0, 50, 0)});
    rows.push_back('{make_key(8'h16, 0, 0, 1, 7, 250, 0), 1, make_decision(1, 1, 250, 0)});
    rows.push_back('{make_key(8'h2A, 1, 16'hFFFF, 1, 0, 0, 0), 0, '0});
    rows.push_back('{make_key(8'h33, 1, 0, 1, 16'hFFFF, 0, 0), 0, '0});
    rows.push_back('{make_key(8'h1D, 1, 16'hFFFF, 1, 16'hFFFF, 0, 0), 0, '0});
    rows.push_back('{make_key(8'h28, 1, 120, 1, 40, 0, 0), 0, '0});
    rows.push_back('{make_key(8'h2B, 1, 0, 0, 0, 16'hFFFF, 0), 0, '0});
    rows.push_back('{make_key(8'h2B, 1, 200, 0, 0, 249, 0), 0, '0});
    rows.push_back('{make_key(8'h2B, 1, 130, 0, 0, 73, 0), 0, '0});
    rows.push_back('{make_key(8'h2B, 1, 16'hFFFF, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_key(8'h1D, 1, 100, 0, 0, 50, 0), 0, '0});
    rows.push_back('{make_key(8'h1D, 1, 16'hFFFF, 0, 0, 250, 0), 0, '0});
    rows.push_back('{make_key(8'h00, 0, 0, 1, 0, 16'hFFFF, 0), 0, '0});
    rows.push_back('{make_key(8'h2C, 0, 0, 1, 16'hFFFF, 249, 0), 0, '0});
    rows.push_back('{make_key(8'h33, 0, 0, 1, 100, 145, 0), 0, '0});
    rows.push_back('{make_key(8'hFF, 0, 0, 1, 0, 199, 0), 0, '0});
    foreach (rows[i]) offer_key(rows[i].k, rows[i].typed, rows[i].want);

    wait_settings[7] = wait_t'($urandom);
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 2; c++) begin
        set_min_wait(wait_settings[2 * p + c]);
        gap_pct = gap_plan[p];
        stall_pct = stall_plan[p];
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          if (n == ITEMS_PER_SETTING / 2) drain_decisions();
          offer_key(random_key(), 1'b0, '0);
        end
      end
    end

    drain_decisions();
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
